@@ rtl/acidseq_pkg.sv @@
`timescale 1ns / 1ps

package acidseq_pkg;

  localparam int MAX_STEPS   = 16;
  localparam int STACK_SLOTS = 8;

  localparam int POS_W     = $clog2(MAX_STEPS);
  localparam int LEN_W     = $clog2(MAX_STEPS + 1);
  localparam int SLOT_W    = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
  localparam int REM_W     = 12;
  localparam int TICK_W    = 32;
  localparam int MOD_BITS  = 2;
  localparam int MOD_ITERS = TICK_W / MOD_BITS;
  localparam int MOD_CNT_W = $clog2(MOD_ITERS);

  localparam int NUM_REGS = 7;
  localparam int ADDR_W   = $clog2(NUM_REGS * 4);
  localparam int DATA_W   = 32;

  localparam int         SLIDE_EXTRA = 6;
  localparam logic [6:0] RESET_NOTE  = 7'd36;

  localparam logic [4:0] RST_PATTERN_LENGTH  = 5'd16;
  localparam logic [7:0] RST_STEP_SHIFT      = 8'd0;
  localparam logic [7:0] RST_TRANSPOSE       = 8'd0;
  localparam logic [3:0] RST_MIDI_CHANNEL    = 4'd0;
  localparam logic [7:0] RST_GATE_LENGTH     = 8'd5;
  localparam logic [6:0] RST_ACCENT_VELOCITY = 7'd127;
  localparam logic [6:0] RST_NORMAL_VELOCITY = 7'd100;

  localparam logic EV_NOTE_ON  = 1'b0;
  localparam logic EV_NOTE_OFF = 1'b1;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_CLOCK = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_PATTERN_LENGTH  = 3'd0,
    REG_STEP_SHIFT      = 3'd1,
    REG_TRANSPOSE       = 3'd2,
    REG_MIDI_CHANNEL    = 3'd3,
    REG_GATE_LENGTH     = 3'd4,
    REG_ACCENT_VELOCITY = 3'd5,
    REG_NORMAL_VELOCITY = 3'd6
  } reg_idx_e;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] tick;
    logic [3:0]  step_index;
    logic [6:0]  step_note;
    logic        step_accent;
    logic        step_slide;
    logic        step_rest;
  } req_t;

  typedef struct packed {
    logic       event_kind;
    logic [6:0] note_number;
    logic [6:0] velocity;
    logic [3:0] channel;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [4:0]        pattern_length;
    logic signed [7:0] step_shift;
    logic signed [7:0] transpose;
    logic [3:0]        midi_channel;
    logic [7:0]        gate_length;
    logic [6:0]        accent_velocity;
    logic [6:0]        normal_velocity;
  } cfg_t;

  typedef struct packed {
    logic [6:0] note;
    logic       accent;
    logic       slide;
    logic       rest;
  } step_t;

  typedef struct packed {
    logic load_tick;
    logic load_clock;
    logic load_clear;
    logic write_step;
    logic mod_step;
    logic read_pos;
    logic look_step;
    logic place;
    logic walk;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_last;
    logic pos_rest;
    logic look_fin;
    logic walk_empty;
  } dp_status_t;

endpackage

@@ rtl/acidseq_ctrl.sv @@
`timescale 1ns / 1ps

module acidseq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  acidseq_pkg::mode_e     mode_i,
  input  acidseq_pkg::dp_status_t status_i,
  output acidseq_pkg::dp_cmd_t   cmd_o,
  output logic                   busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_LOOK,
    ST_SLOT,
    ST_WALK
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (mode_i)
            acidseq_pkg::MODE_TICK: begin
              cmd_o.load_tick = 1'b1;
              state_d         = ST_MOD;
            end
            acidseq_pkg::MODE_CLOCK: begin
              cmd_o.load_clock = 1'b1;
              state_d          = ST_WALK;
            end
            acidseq_pkg::MODE_WRITE: begin
              cmd_o.write_step = 1'b1;
            end
            acidseq_pkg::MODE_CLEAR: begin
              cmd_o.load_clear = 1'b1;
              state_d          = ST_WALK;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) state_d = ST_READ;
      end
      ST_READ: begin
        cmd_o.read_pos = 1'b1;
        state_d        = status_i.pos_rest ? ST_IDLE : ST_LOOK;
      end
      ST_LOOK: begin
        cmd_o.look_step = 1'b1;
        if (status_i.look_fin) state_d = ST_SLOT;
      end
      ST_SLOT: begin
        cmd_o.place = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_WALK: begin
        if (status_i.walk_empty) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

@@ rtl/acidseq_dp.sv @@
`timescale 1ns / 1ps

module acidseq_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  acidseq_pkg::req_t       req_i,
  input  acidseq_pkg::cfg_t       cfg_i,
  input  acidseq_pkg::dp_cmd_t    cmd_i,
  output acidseq_pkg::dp_status_t status_o,
  output acidseq_pkg::result_t    result_o,
  output logic                    result_valid_o
);

  localparam int POS_W  = acidseq_pkg::POS_W;
  localparam int LEN_W  = acidseq_pkg::LEN_W;
  localparam int SLOT_W = acidseq_pkg::SLOT_W;
  localparam int REM_W  = acidseq_pkg::REM_W;
  localparam int TICK_W = acidseq_pkg::TICK_W;
  localparam int NSLOT  = acidseq_pkg::STACK_SLOTS;

  acidseq_pkg::step_t step_q [acidseq_pkg::MAX_STEPS];
  logic [6:0]         slot_note_q [NSLOT];
  logic [REM_W-1:0]   slot_rem_q [NSLOT];
  logic [NSLOT-1:0]   mask_q;

  logic [TICK_W-1:0]                    div_q;
  logic [POS_W-1:0]                     rem_q;
  logic [acidseq_pkg::MOD_CNT_W-1:0]    mcnt_q;
  logic signed [8:0]                    note_q;
  logic                                 accent_q;
  logic [POS_W-1:0]                     look_q;
  logic [LEN_W-1:0]                     dist_q;
  logic [REM_W-1:0]                     total_q;

  acidseq_pkg::result_t res_q, res_d;
  logic                 res_valid_q, res_valid_d;

  logic [LEN_W-1:0]   len;
  logic [POS_W-1:0]   mod_rem;
  logic [LEN_W:0]     part;
  logic [POS_W-1:0]   r;
  acidseq_pkg::step_t pos_step;
  acidseq_pkg::step_t nxt_step;
  logic [LEN_W-1:0]   look_inc;
  logic [POS_W-1:0]   look_nxt;
  logic               look_hit;
  logic [SLOT_W-1:0]  free_idx;
  logic               free_any;
  logic [SLOT_W-1:0]  walk_idx;
  logic [NSLOT-1:0]   walk_left;
  logic               note_ok;

  always_comb begin
    if (cfg_i.pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (int'(cfg_i.pattern_length) > acidseq_pkg::MAX_STEPS) begin
      len = LEN_W'(acidseq_pkg::MAX_STEPS);
    end else begin
      len = LEN_W'(cfg_i.pattern_length);
    end
  end

  // restoring remainder, MOD_BITS dividend bits a cycle
  always_comb begin
    r    = rem_q;
    part = '0;
    for (int k = 0; k < acidseq_pkg::MOD_BITS; k++) begin
      part = {LEN_W'(r), div_q[TICK_W-1-k]};
      if (part >= {1'b0, len}) part = part - {1'b0, len};
      r = part[POS_W-1:0];
    end
    mod_rem = r;
  end

  assign pos_step = step_q[rem_q];

  assign look_inc = LEN_W'(look_q) + LEN_W'(1);
  assign look_nxt = (look_inc == len) ? '0 : look_inc[POS_W-1:0];
  assign nxt_step = step_q[look_nxt];
  assign look_hit = nxt_step.slide & nxt_step.rest;

  always_comb begin
    free_idx = '0;
    for (int s = NSLOT - 1; s >= 0; s--) begin
      if (slot_rem_q[s] == '0) free_idx = SLOT_W'(s);
    end
    walk_idx = '0;
    for (int s = NSLOT - 1; s >= 0; s--) begin
      if (mask_q[s]) walk_idx = SLOT_W'(s);
    end
    free_any = 1'b0;
    for (int s = 0; s < NSLOT; s++) begin
      if (slot_rem_q[s] == '0) free_any = 1'b1;
    end
    walk_left           = mask_q;
    walk_left[walk_idx] = 1'b0;
  end

  assign note_ok = (note_q[8:7] == 2'b00);

  assign status_o.mod_last   = (mcnt_q == acidseq_pkg::MOD_CNT_W'(acidseq_pkg::MOD_ITERS - 1));
  assign status_o.pos_rest   = pos_step.rest;
  assign status_o.look_fin   = (dist_q >= len) | look_hit | !nxt_step.rest;
  assign status_o.walk_empty = (mask_q == '0);

  always_comb begin
    res_valid_d = 1'b0;
    res_d       = res_q;
    if (cmd_i.place && note_ok && free_any) begin
      res_valid_d       = 1'b1;
      res_d.event_kind  = acidseq_pkg::EV_NOTE_ON;
      res_d.note_number = note_q[6:0];
      res_d.velocity    = accent_q ? cfg_i.accent_velocity : cfg_i.normal_velocity;
      res_d.channel     = cfg_i.midi_channel;
      res_d.last        = 1'b1;
    end else if (cmd_i.walk) begin
      res_valid_d       = 1'b1;
      res_d.event_kind  = acidseq_pkg::EV_NOTE_OFF;
      res_d.note_number = slot_note_q[walk_idx];
      res_d.velocity    = '0;
      res_d.channel     = cfg_i.midi_channel;
      res_d.last        = (walk_left == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < acidseq_pkg::MAX_STEPS; i++) begin
        step_q[i] <= '{note: acidseq_pkg::RESET_NOTE, accent: 1'b0, slide: 1'b0, rest: 1'b0};
      end
      for (int s = 0; s < NSLOT; s++) begin
        slot_note_q[s] <= '0;
        slot_rem_q[s]  <= '0;
      end
      mask_q      <= '0;
      mcnt_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (cmd_i.write_step && (int'(req_i.step_index) < acidseq_pkg::MAX_STEPS)) begin
        step_q[POS_W'(req_i.step_index)] <= '{note: req_i.step_note,
                                              accent: req_i.step_accent,
                                              slide: req_i.step_slide,
                                              rest: req_i.step_rest};
      end
      if (cmd_i.load_tick) mcnt_q <= '0;
      if (cmd_i.mod_step)  mcnt_q <= mcnt_q + 1'b1;
      if (cmd_i.load_clock) begin
        for (int s = 0; s < NSLOT; s++) begin
          mask_q[s] <= (slot_rem_q[s] == REM_W'(1));
          if (slot_rem_q[s] != '0) slot_rem_q[s] <= slot_rem_q[s] - 1'b1;
        end
      end
      if (cmd_i.load_clear) begin
        mask_q <= '1;
        for (int s = 0; s < NSLOT; s++) begin
          slot_rem_q[s] <= '0;
        end
      end
      if (cmd_i.walk) mask_q[walk_idx] <= 1'b0;
      if (cmd_i.place && note_ok && free_any) begin
        slot_note_q[free_idx] <= note_q[6:0];
        slot_rem_q[free_idx]  <= (total_q == '0) ? REM_W'(1) : total_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.load_tick) begin
      div_q <= req_i.tick + {{(TICK_W - 8){cfg_i.step_shift[7]}}, cfg_i.step_shift};
      rem_q <= '0;
    end
    if (cmd_i.mod_step) begin
      div_q <= div_q << acidseq_pkg::MOD_BITS;
      rem_q <= mod_rem;
    end
    if (cmd_i.read_pos) begin
      note_q   <= $signed({2'b00, pos_step.note}) + $signed({cfg_i.transpose[7], cfg_i.transpose});
      accent_q <= pos_step.accent;
      look_q   <= rem_q;
      dist_q   <= LEN_W'(1);
      total_q  <= REM_W'(cfg_i.gate_length);
    end
    if (cmd_i.look_step && (dist_q < len)) begin
      look_q <= look_nxt;
      dist_q <= dist_q + 1'b1;
      if (look_hit) begin
        total_q <= REM_W'(cfg_i.gate_length)
                 + REM_W'(dist_q) * REM_W'(acidseq_pkg::SLIDE_EXTRA);
      end
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

endmodule

@@ rtl/acid_step_sequencer_note_stack.sv @@
`timescale 1ns / 1ps

// One track of a 303-style step sequencer with an eight-slot note stack.
// A request is taken when start is high and busy is low. Results appear one
// per cycle on result_o, each marked by result_valid_o for a single cycle, and
// must be taken there and then: there is no back-pressure. A step write leaves
// busy low. A step tick keeps busy high through the position remainder (two
// tick bits a cycle) and one step read, and when the step is not a rest also
// through a look-ahead over the following steps, which stops at a slid rest, a
// played step or a full lap of the pattern length (taken as 1 to 16), and one
// slot placement. It gives at most one note-on, shown in the cycle in which
// busy falls. A clock pulse gives a note-off for each slot whose gate runs
// out; a stack clear always gives 8 note-offs.

module acid_step_sequencer_note_stack (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  acidseq_pkg::req_t                  req_i,
  output acidseq_pkg::result_t               result_o,
  output logic                               result_valid_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [acidseq_pkg::ADDR_W-1:0]     paddr,
  input  logic [acidseq_pkg::DATA_W-1:0]     pwdata,
  output logic [acidseq_pkg::DATA_W-1:0]     prdata,
  output logic                               pready
);

  acidseq_pkg::cfg_t       cfg_q;
  acidseq_pkg::dp_cmd_t    cmd;
  acidseq_pkg::dp_status_t status;
  acidseq_pkg::reg_idx_e   reg_idx;
  logic                    cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = acidseq_pkg::reg_idx_e'(paddr[acidseq_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_length  <= acidseq_pkg::RST_PATTERN_LENGTH;
      cfg_q.step_shift      <= acidseq_pkg::RST_STEP_SHIFT;
      cfg_q.transpose       <= acidseq_pkg::RST_TRANSPOSE;
      cfg_q.midi_channel    <= acidseq_pkg::RST_MIDI_CHANNEL;
      cfg_q.gate_length     <= acidseq_pkg::RST_GATE_LENGTH;
      cfg_q.accent_velocity <= acidseq_pkg::RST_ACCENT_VELOCITY;
      cfg_q.normal_velocity <= acidseq_pkg::RST_NORMAL_VELOCITY;
    end else if (cfg_wr) begin
      case (reg_idx)
        acidseq_pkg::REG_PATTERN_LENGTH:  cfg_q.pattern_length  <= pwdata[4:0];
        acidseq_pkg::REG_STEP_SHIFT:      cfg_q.step_shift      <= pwdata[7:0];
        acidseq_pkg::REG_TRANSPOSE:       cfg_q.transpose       <= pwdata[7:0];
        acidseq_pkg::REG_MIDI_CHANNEL:    cfg_q.midi_channel    <= pwdata[3:0];
        acidseq_pkg::REG_GATE_LENGTH:     cfg_q.gate_length     <= pwdata[7:0];
        acidseq_pkg::REG_ACCENT_VELOCITY: cfg_q.accent_velocity <= pwdata[6:0];
        acidseq_pkg::REG_NORMAL_VELOCITY: cfg_q.normal_velocity <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      acidseq_pkg::REG_PATTERN_LENGTH:  prdata = {27'b0, cfg_q.pattern_length};
      acidseq_pkg::REG_STEP_SHIFT:      prdata = {24'b0, cfg_q.step_shift};
      acidseq_pkg::REG_TRANSPOSE:       prdata = {24'b0, cfg_q.transpose};
      acidseq_pkg::REG_MIDI_CHANNEL:    prdata = {28'b0, cfg_q.midi_channel};
      acidseq_pkg::REG_GATE_LENGTH:     prdata = {24'b0, cfg_q.gate_length};
      acidseq_pkg::REG_ACCENT_VELOCITY: prdata = {25'b0, cfg_q.accent_velocity};
      acidseq_pkg::REG_NORMAL_VELOCITY: prdata = {25'b0, cfg_q.normal_velocity};
      default:                          prdata = '0;
    endcase
  end

  acidseq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .mode_i   (req_i.mode),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  acidseq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

@@ rtl/acidseq_chk.sv @@
`timescale 1ns / 1ps

module acidseq_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input acidseq_pkg::req_t              req_i,
  input acidseq_pkg::result_t           result_o,
  input logic                           result_valid_o
);

  // no result in the cycle straight after a request is taken
  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !result_valid_o)
    else $error("result right after request accept");

  // a clear ends with its last note-off after one per slot
  a_clear_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (req_i.mode == acidseq_pkg::MODE_CLEAR)
      |-> ##(acidseq_pkg::STACK_SLOTS + 1) (result_valid_o && result_o.last))
    else $error("clear burst length wrong");

  a_off_velocity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.event_kind == acidseq_pkg::EV_NOTE_OFF)
      |-> (result_o.velocity == '0))
    else $error("note-off with non-zero velocity");

  // a burst is note-offs on back-to-back cycles
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last
      |=> result_valid_o && (result_o.event_kind == acidseq_pkg::EV_NOTE_OFF))
    else $error("burst broken");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |=> !result_valid_o)
    else $error("result after last");

endmodule

bind acid_step_sequencer_note_stack acidseq_chk u_chk (.*);

@@ sim/note_event_checker.sv @@
`timescale 1ns / 1ps

module note_event_checker
  import acidseq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  req_t              req_i,
  input  result_t           result_i,
  input  logic              result_valid_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int NOTE_MAX = 127;

  step_t            pattern     [MAX_STEPS];
  logic [6:0]       held_note   [STACK_SLOTS];
  logic [REM_W-1:0] pulses_left [STACK_SLOTS];
  cfg_t             cfg;
  result_t          due_events[$];
  int               fail_count;

  function automatic void reset_model();
    for (int i = 0; i < MAX_STEPS; i++) begin
      pattern[i] = '{note: RESET_NOTE, accent: 1'b0, slide: 1'b0, rest: 1'b0};
    end
    for (int s = 0; s < STACK_SLOTS; s++) begin
      held_note[s]   = '0;
      pulses_left[s] = '0;
    end
    cfg.pattern_length  = RST_PATTERN_LENGTH;
    cfg.step_shift      = RST_STEP_SHIFT;
    cfg.transpose       = RST_TRANSPOSE;
    cfg.midi_channel    = RST_MIDI_CHANNEL;
    cfg.gate_length     = RST_GATE_LENGTH;
    cfg.accent_velocity = RST_ACCENT_VELOCITY;
    cfg.normal_velocity = RST_NORMAL_VELOCITY;
    due_events.delete();
  endfunction

  function automatic void write_register(logic [2:0] idx, logic [DATA_W-1:0] d);
    case (reg_idx_e'(idx))
      REG_PATTERN_LENGTH:  cfg.pattern_length  = d[4:0];
      REG_STEP_SHIFT:      cfg.step_shift      = d[7:0];
      REG_TRANSPOSE:       cfg.transpose       = d[7:0];
      REG_MIDI_CHANNEL:    cfg.midi_channel    = d[3:0];
      REG_GATE_LENGTH:     cfg.gate_length     = d[7:0];
      REG_ACCENT_VELOCITY: cfg.accent_velocity = d[6:0];
      REG_NORMAL_VELOCITY: cfg.normal_velocity = d[6:0];
      default: ;
    endcase
  endfunction

  function automatic void push_event(logic kind, logic [6:0] note, logic [6:0] vel);
    result_t ev;
    ev.event_kind  = kind;
    ev.note_number = note;
    ev.velocity    = vel;
    ev.channel     = cfg.midi_channel;
    ev.last        = 1'b0;
    due_events.push_back(ev);
  endfunction

  function automatic void play_step(logic [31:0] tick);
    int unsigned len;
    int unsigned pos;
    int unsigned look;
    int unsigned gate;
    int unsigned i;
    logic [31:0] shifted;
    int          note;
    len = cfg.pattern_length;
    if (len == 0) len = 1;
    if (len > MAX_STEPS) len = MAX_STEPS;
    shifted = tick + {{24{cfg.step_shift[7]}}, cfg.step_shift};
    pos = shifted % len;
    if (pattern[pos].rest) return;
    gate = cfg.gate_length;
    look = pos;
    for (i = 1; i < len; i++) begin
      look = (look + 1) % len;
      if (pattern[look].slide && pattern[look].rest) begin
        gate = cfg.gate_length + i * SLIDE_EXTRA;
        break;
      end
      if (!pattern[look].rest) break;
    end
    if (gate == 0) gate = 1;
    note = int'(pattern[pos].note) + int'($signed(cfg.transpose));
    if (note < 0 || note > NOTE_MAX) return;
    for (int s = 0; s < STACK_SLOTS; s++) begin
      if (pulses_left[s] == 0) begin
        held_note[s]   = note[6:0];
        pulses_left[s] = REM_W'(gate);
        push_event(EV_NOTE_ON, note[6:0],
                   pattern[pos].accent ? cfg.accent_velocity : cfg.normal_velocity);
        return;
      end
    end
  endfunction

  function automatic void pulse_clock();
    for (int s = 0; s < STACK_SLOTS; s++) begin
      if (pulses_left[s] != 0) begin
        pulses_left[s] = pulses_left[s] - 1'b1;
        if (pulses_left[s] == 0) push_event(EV_NOTE_OFF, held_note[s], 7'd0);
      end
    end
  endfunction

  function automatic void clear_stack();
    for (int s = 0; s < STACK_SLOTS; s++) begin
      push_event(EV_NOTE_OFF, held_note[s], 7'd0);
      pulses_left[s] = '0;
    end
  endfunction

  function automatic void predict_request(req_t r);
    int      queued;
    result_t tail;
    queued = due_events.size();
    case (r.mode)
      MODE_TICK:  play_step(r.tick);
      MODE_CLOCK: pulse_clock();
      MODE_WRITE: begin
        if (int'(r.step_index) < MAX_STEPS) begin
          pattern[r.step_index] = '{note: r.step_note, accent: r.step_accent,
                                    slide: r.step_slide, rest: r.step_rest};
        end
      end
      default:    clear_stack();
    endcase
    if (due_events.size() > queued) begin
      tail = due_events.pop_back();
      tail.last = 1'b1;
      due_events.push_back(tail);
    end
  endfunction

  function automatic void match_event(result_t got);
    result_t want;
    if (due_events.size() == 0) begin
      $error("note event with none due: kind %0d note %0d", got.event_kind, got.note_number);
      fail_count++;
      return;
    end
    want = due_events.pop_front();
    if (got.event_kind !== want.event_kind) begin
      $error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
      fail_count++;
    end
    if (got.note_number !== want.note_number) begin
      $error("note_number: expected %0d, got %0d", want.note_number, got.note_number);
      fail_count++;
    end
    if (got.velocity !== want.velocity) begin
      $error("velocity: expected %0d, got %0d", want.velocity, got.velocity);
      fail_count++;
    end
    if (got.channel !== want.channel) begin
      $error("channel: expected %0d, got %0d", want.channel, got.channel);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      fail_count++;
    end
  endfunction

  // results belong to earlier requests, so they are matched before a new request is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
      fail_count = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (result_valid_i) match_event(result_i);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        write_register(paddr_i[ADDR_W-1:2], pwdata_i);
      end
      if (start_i && !busy_i) predict_request(req_i);
      fail_count_o <= fail_count;
      pending_o    <= due_events.size();
    end
  end

endmodule

@@ sim/acid_step_sequencer_note_stack_test.sv @@
`timescale 1ns / 1ps

module acid_step_sequencer_note_stack_test;
  import acidseq_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          PHASES        = 7;
  localparam int          PHASE_ITEMS   = 50;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start        = 1'b0;
  logic              busy;
  req_t              req          = '0;
  result_t           result;
  logic              result_valid;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [ADDR_W-1:0] paddr        = '0;
  logic [DATA_W-1:0] pwdata       = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  bit          no_idle     = 1'b0;
  logic [31:0] tick_count  = '0;

  always #5 clk_i = ~clk_i;

  acid_step_sequencer_note_stack u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .result_o       (result),
    .result_valid_o (result_valid),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  note_event_checker u_events (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req),
    .result_i       (result),
    .result_valid_i (result_valid),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int k;
    if (no_idle) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t make_req(mode_e m);
    req_t r;
    r.mode        = m;
    r.tick        = $urandom();
    r.step_index  = 4'($urandom_range(0, 15));
    r.step_note   = 7'($urandom_range(0, 127));
    r.step_accent = 1'($urandom_range(0, 1));
    r.step_slide  = 1'($urandom_range(0, 1));
    r.step_rest   = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic req_t step_write(int idx, int note, bit acc, bit sl, bit rst);
    req_t r;
    r             = make_req(MODE_WRITE);
    r.step_index  = idx[3:0];
    r.step_note   = note[6:0];
    r.step_accent = acc;
    r.step_slide  = sl;
    r.step_rest   = rst;
    return r;
  endfunction

  function automatic req_t step_tick(logic [31:0] t);
    req_t r;
    r      = make_req(MODE_TICK);
    r.tick = t;
    return r;
  endfunction

  // called at a clock edge; returns at the edge that takes the request, start left high
  task automatic issue(req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic configure(cfg_t c);
    write_reg(REG_PATTERN_LENGTH, 32'(c.pattern_length));
    write_reg(REG_STEP_SHIFT, {{24{c.step_shift[7]}}, c.step_shift});
    write_reg(REG_TRANSPOSE, {{24{c.transpose[7]}}, c.transpose});
    write_reg(REG_MIDI_CHANNEL, 32'(c.midi_channel));
    write_reg(REG_GATE_LENGTH, 32'(c.gate_length));
    write_reg(REG_ACCENT_VELOCITY, 32'(c.accent_velocity));
    write_reg(REG_NORMAL_VELOCITY, 32'(c.normal_velocity));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic cfg_t phase_setting(int p);
    cfg_t c;
    c.pattern_length  = 5'($urandom_range(1, 16));
    c.step_shift      = 8'($urandom_range(0, 255));
    c.transpose       = 8'($urandom_range(0, 48) - 24);
    c.midi_channel    = 4'($urandom_range(0, 15));
    c.gate_length     = 8'($urandom_range(1, 12));
    c.accent_velocity = 7'($urandom_range(0, 127));
    c.normal_velocity = 7'($urandom_range(0, 127));
    case (p)
      0: begin
        c.pattern_length  = 5'd1;
        c.step_shift      = 8'h80;
        c.transpose       = 8'h7F;
        c.midi_channel    = 4'd15;
        c.gate_length     = 8'd255;
        c.accent_velocity = 7'd0;
        c.normal_velocity = 7'd127;
      end
      1: begin
        c.pattern_length  = 5'd0;
        c.step_shift      = 8'h7F;
        c.transpose       = 8'h80;
        c.midi_channel    = 4'd0;
        c.gate_length     = 8'd1;
        c.accent_velocity = 7'd127;
        c.normal_velocity = 7'd0;
      end
      2: begin
        c.pattern_length = 5'd31;
        c.step_shift     = 8'hFF;
        c.transpose      = 8'h00;
        c.gate_length    = 8'd0;
      end
      3: c.pattern_length = 5'd17;
      default: ;
    endcase
    return c;
  endfunction

  task automatic random_item();
    int   k;
    req_t r;
    k = $urandom_range(0, 99);
    if (k < 30) begin
      if ($urandom_range(0, 9) == 0) begin
        r = make_req(MODE_TICK);
      end else begin
        r = step_tick(tick_count);
        tick_count = tick_count + 1;
      end
    end else if (k < 65) begin
      r = make_req(MODE_CLOCK);
    end else if (k < 90) begin
      r = step_write($urandom_range(0, 15), $urandom_range(0, 127), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0);
    end else begin
      r = make_req(MODE_CLEAR);
    end
    issue(r);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: slid-rest look-ahead, wrap of the tick, rests, clear, full stack
    issue(step_write(0, 127, 1'b1, 1'b0, 1'b0));
    issue(step_write(1, 0, 1'b0, 1'b1, 1'b1));
    issue(step_write(2, 64, 1'b0, 1'b0, 1'b1));
    issue(step_write(15, 1, 1'b1, 1'b1, 1'b0));
    issue(step_tick(32'd0));
    issue(step_tick(32'hFFFF_FFFF));
    issue(step_tick(32'd1));
    issue(make_req(MODE_CLOCK));
    issue(make_req(MODE_CLEAR));
    for (int t = 3; t < 12; t++) issue(step_tick(32'(t)));
    repeat (5) issue(make_req(MODE_CLOCK));
    issue(step_tick(32'h7FFF_FFFF));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      configure(phase_setting(p));
      @(posedge clk_i);
      no_idle = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 10 == 0) no_idle = ($urandom_range(0, 3) == 0);
        random_item();
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/acidseq_pkg.sv
rtl/acidseq_ctrl.sv
rtl/acidseq_dp.sv
rtl/acid_step_sequencer_note_stack.sv
rtl/acidseq_chk.sv
sim/note_event_checker.sv
sim/acid_step_sequencer_note_stack_test.sv
